FILE: hw/rtl/ptwcs_pkg.sv
package ptwcs_pkg;

    // Length of an address or data frame in bits, MSB first.
    localparam int FRAME_BITS = 16;
    // The read frame always has sixteen bits: eight command bits, eight sampled bits.
    localparam int READ_FRAME_BITS = 16;
    localparam int RECV_BITS = 8;
    localparam int SHIFT_W = (FRAME_BITS > READ_FRAME_BITS) ? FRAME_BITS : READ_FRAME_BITS;
    localparam int BIT_W = $clog2(SHIFT_W + 1);

    localparam int TICK_W = 16;
    localparam int CFG_W = 16;
    localparam int CFG_IDX_W = 2;

    localparam int IN_TDATA_W = 32;
    localparam int OUT_TDATA_W = 16;

    localparam logic [15:0] ADDR_HI_PREFIX = 16'h2000;
    localparam logic [15:0] DATA_PREFIX = 16'h4000;
    localparam logic [7:0] READ_CMD = 8'hC0;
    localparam logic [15:0] LOW_BYTE_MASK = 16'h00FF;

    localparam logic [TICK_W-1:0] WRITE_HALF_RESET = 16'd5;
    localparam logic [TICK_W-1:0] READ_HALF_RESET = 16'd20;
    localparam logic [TICK_W-1:0] FRAME_GAP_RESET = 16'd5;
    localparam logic [TICK_W-1:0] READ_GAP_TICKS = 16'd1;

    typedef enum logic [1:0] {
        OP_NONE    = 2'd0,
        OP_ADDR_WR = 2'd1,
        OP_DATA_WR = 2'd2,
        OP_READ    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        PH_LOW  = 2'd0,
        PH_HIGH = 2'd1,
        PH_GAP  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        FR_ADDR_HI = 2'd0,
        FR_ADDR_LO = 2'd1,
        FR_THIRD   = 2'd2
    } frame_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WRITE_HALF = 2'd0,
        CFG_READ_HALF  = 2'd1,
        CFG_FRAME_GAP  = 2'd2
    } cfg_index_t;

    // Members are listed from the highest bit down, so op sits in the lowest bits.
    typedef struct packed {
        logic        serial_in;
        logic [7:0]  write_data;
        logic [15:0] reg_address;
        op_t         op;
    } in_item_t;

    typedef struct packed {
        logic       start_ignored;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       done_res;
        logic       busy_res;
        logic       serial_out;
        logic       serial_clock;
        logic       chip_select_n;
    } res_item_t;

    localparam int IN_W = $bits(in_item_t);
    localparam int OUT_W = $bits(res_item_t);

endpackage

FILE: hw/rtl/ptwcs_in_reg.sv
module ptwcs_in_reg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  ptwcs_pkg::in_item_t  s_item,
    input  logic                 step,
    output logic                 item_valid,
    output ptwcs_pkg::in_item_t  item
);

    logic                valid_reg;
    logic                valid_next;
    ptwcs_pkg::in_item_t item_reg;
    logic                take;

    // The slot frees up in the same cycle that its word moves on.
    assign s_tready = !valid_reg || step;
    assign take = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (step) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item = item_reg;

endmodule

FILE: hw/rtl/ptwcs_out_reg.sv
module ptwcs_out_reg (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  ptwcs_pkg::res_item_t  res,
    output logic                  can_load,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output ptwcs_pkg::res_item_t  m_res
);

    logic                 valid_reg;
    logic                 valid_next;
    ptwcs_pkg::res_item_t res_reg;

    assign can_load = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (step) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_res = res_reg;

endmodule

FILE: hw/rtl/ptwcs_core.sv
module ptwcs_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [ptwcs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ptwcs_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                                 step,
    input  ptwcs_pkg::in_item_t                  item,
    output ptwcs_pkg::res_item_t                 res
);

    logic [ptwcs_pkg::TICK_W-1:0]  write_half_reg;
    logic [ptwcs_pkg::TICK_W-1:0]  read_half_reg;
    logic [ptwcs_pkg::TICK_W-1:0]  frame_gap_reg;

    ptwcs_pkg::op_t                active_op_reg, active_op_next;
    ptwcs_pkg::frame_t             frame_reg, frame_next;
    logic [ptwcs_pkg::BIT_W-1:0]   bit_reg, bit_next;
    ptwcs_pkg::phase_t             phase_reg, phase_next;
    logic [ptwcs_pkg::TICK_W-1:0]  tick_reg, tick_next;
    logic [ptwcs_pkg::SHIFT_W-1:0] shift_reg, shift_next;
    logic [15:0]                   addr_reg, addr_next;
    logic [7:0]                    data_reg, data_next;
    logic [7:0]                    recv_reg, recv_next;

    logic                          read_frame;
    logic [ptwcs_pkg::BIT_W-1:0]   frame_len;
    logic [ptwcs_pkg::TICK_W-1:0]  half_ticks;
    logic [ptwcs_pkg::TICK_W-1:0]  gap_ticks;
    logic [ptwcs_pkg::TICK_W:0]    tick_inc;
    logic [ptwcs_pkg::BIT_W-1:0]   bit_inc;
    logic                          last_frame;

    // Word for a given frame, zero-extended to the shift register.
    function automatic logic [ptwcs_pkg::SHIFT_W-1:0] frame_word(
        input ptwcs_pkg::frame_t fr,
        input ptwcs_pkg::op_t    op,
        input logic [15:0]       addr,
        input logic [7:0]        data
    );
        logic [15:0] w;
        case (fr)
            ptwcs_pkg::FR_ADDR_HI: begin
                w = ptwcs_pkg::ADDR_HI_PREFIX | ((addr >> 8) & ptwcs_pkg::LOW_BYTE_MASK);
            end
            ptwcs_pkg::FR_ADDR_LO: begin
                w = addr & ptwcs_pkg::LOW_BYTE_MASK;
            end
            default: begin
                if (op == ptwcs_pkg::OP_READ) begin
                    w = {ptwcs_pkg::READ_CMD, 8'h00};
                end else begin
                    w = ptwcs_pkg::DATA_PREFIX | {8'h00, data};
                end
            end
        endcase
        return ptwcs_pkg::SHIFT_W'(w);
    endfunction

    always_comb begin
        active_op_next = active_op_reg;
        frame_next = frame_reg;
        bit_next = bit_reg;
        phase_next = phase_reg;
        tick_next = tick_reg;
        shift_next = shift_reg;
        addr_next = addr_reg;
        data_next = data_reg;
        recv_next = recv_reg;
        res = '0;
        res.chip_select_n = 1'b1;
        res.serial_clock = 1'b1;
        read_frame = 1'b0;
        frame_len = ptwcs_pkg::BIT_W'(ptwcs_pkg::FRAME_BITS);
        half_ticks = write_half_reg;
        gap_ticks = frame_gap_reg;
        tick_inc = '0;
        bit_inc = '0;
        last_frame = 1'b0;

        // A start while an operation runs is dropped and flagged.
        if (item.op != ptwcs_pkg::OP_NONE) begin
            if (active_op_reg != ptwcs_pkg::OP_NONE) begin
                res.start_ignored = 1'b1;
            end else begin
                addr_next = item.reg_address;
                data_next = item.write_data;
                active_op_next = item.op;
                frame_next = ptwcs_pkg::FR_ADDR_HI;
                shift_next = frame_word(ptwcs_pkg::FR_ADDR_HI, item.op,
                                        item.reg_address, item.write_data);
                bit_next = '0;
                phase_next = ptwcs_pkg::PH_LOW;
                tick_next = '0;
            end
        end

        if (active_op_next != ptwcs_pkg::OP_NONE) begin
            read_frame = (active_op_next == ptwcs_pkg::OP_READ) &&
                         (frame_next == ptwcs_pkg::FR_THIRD);
            if (read_frame) begin
                frame_len = ptwcs_pkg::BIT_W'(ptwcs_pkg::READ_FRAME_BITS);
            end
            if (active_op_next == ptwcs_pkg::OP_READ) begin
                half_ticks = read_half_reg;
                gap_ticks = ptwcs_pkg::READ_GAP_TICKS;
            end
            res.busy_res = 1'b1;
            // A zero timing register behaves as one: the first tick already meets it.
            tick_inc = {1'b0, tick_next} + 1'b1;

            if (phase_next == ptwcs_pkg::PH_GAP) begin
                tick_next = tick_inc[ptwcs_pkg::TICK_W-1:0];
                if (tick_inc >= {1'b0, gap_ticks}) begin
                    frame_next = ptwcs_pkg::frame_t'(frame_next + 2'd1);
                    shift_next = frame_word(frame_next, active_op_next, addr_next, data_next);
                    bit_next = '0;
                    phase_next = ptwcs_pkg::PH_LOW;
                    tick_next = '0;
                end
            end else begin
                res.chip_select_n = 1'b0;
                if (read_frame) begin
                    res.serial_out = shift_next[ptwcs_pkg::READ_FRAME_BITS-1];
                end else begin
                    res.serial_out = shift_next[ptwcs_pkg::FRAME_BITS-1];
                end
                tick_next = tick_inc[ptwcs_pkg::TICK_W-1:0];
                if (phase_next == ptwcs_pkg::PH_LOW) begin
                    res.serial_clock = 1'b0;
                    if (tick_inc >= {1'b0, half_ticks}) begin
                        // Sample at the end of the clock-low half of the receive bits.
                        if (read_frame && bit_next >= ptwcs_pkg::BIT_W'(ptwcs_pkg::RECV_BITS)) begin
                            recv_next = {recv_next[6:0], item.serial_in};
                        end
                        phase_next = ptwcs_pkg::PH_HIGH;
                        tick_next = '0;
                    end
                end else begin
                    if (tick_inc >= {1'b0, half_ticks}) begin
                        shift_next = shift_next << 1;
                        bit_inc = bit_next + 1'b1;
                        bit_next = bit_inc;
                        tick_next = '0;
                        phase_next = ptwcs_pkg::PH_LOW;
                        if (bit_inc >= frame_len) begin
                            if (active_op_next == ptwcs_pkg::OP_ADDR_WR) begin
                                last_frame = (frame_next == ptwcs_pkg::FR_ADDR_LO);
                            end else begin
                                last_frame = (frame_next == ptwcs_pkg::FR_THIRD);
                            end
                            if (last_frame) begin
                                res.done_res = 1'b1;
                                res.read_valid = (active_op_next == ptwcs_pkg::OP_READ);
                                active_op_next = ptwcs_pkg::OP_NONE;
                                frame_next = ptwcs_pkg::FR_ADDR_HI;
                                bit_next = '0;
                            end else begin
                                phase_next = ptwcs_pkg::PH_GAP;
                            end
                        end
                    end
                end
            end
        end

        res.read_byte = recv_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_half_reg <= ptwcs_pkg::WRITE_HALF_RESET;
            read_half_reg <= ptwcs_pkg::READ_HALF_RESET;
            frame_gap_reg <= ptwcs_pkg::FRAME_GAP_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                ptwcs_pkg::CFG_WRITE_HALF: begin
                    write_half_reg <= cfg_wdata;
                end
                ptwcs_pkg::CFG_READ_HALF: begin
                    read_half_reg <= cfg_wdata;
                end
                ptwcs_pkg::CFG_FRAME_GAP: begin
                    frame_gap_reg <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_op_reg <= ptwcs_pkg::OP_NONE;
            frame_reg <= ptwcs_pkg::FR_ADDR_HI;
            bit_reg <= '0;
            phase_reg <= ptwcs_pkg::PH_LOW;
            tick_reg <= '0;
            recv_reg <= '0;
        end else if (step) begin
            active_op_reg <= active_op_next;
            frame_reg <= frame_next;
            bit_reg <= bit_next;
            phase_reg <= phase_next;
            tick_reg <= tick_next;
            recv_reg <= recv_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            shift_reg <= shift_next;
            addr_reg <= addr_next;
            data_reg <= data_next;
        end
    end

    a_done_goes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        step && res.done_res |=> active_op_reg == ptwcs_pkg::OP_NONE)
        else $error("operation still active after done");

    a_valid_means_done: assert property (@(posedge aclk) disable iff (!aresetn)
        res.read_valid |-> res.done_res && res.busy_res)
        else $error("read_valid without done");

    a_ignored_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        res.start_ignored |-> active_op_reg != ptwcs_pkg::OP_NONE && res.busy_res)
        else $error("start dropped while idle");

    a_idle_phase_low: assert property (@(posedge aclk) disable iff (!aresetn)
        active_op_reg == ptwcs_pkg::OP_NONE |-> phase_reg == ptwcs_pkg::PH_LOW &&
        tick_reg == '0)
        else $error("idle with timing state left over");

endmodule

FILE: hw/rtl/panel_three_wire_command_serializer.sv
// A word accepted on the input waits in the input register, then goes through the tick
// logic into the output register.
// Throughput: one word per cycle unless the output stalls; each word is one bus timing tick.
// Reset (aresetn low at a clock edge, synchronous) empties both registers, makes the
// serializer idle and restores the timing registers to 5, 20 and 5 ticks.
module panel_three_wire_command_serializer (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    // Timing register writes: index 0 write half period, 1 read half period,
    // 2 frame gap. Other indexes are ignored.
    input  logic                                 cfg_wr_en,
    input  logic [ptwcs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ptwcs_pkg::CFG_W-1:0]          cfg_wdata,

    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // s_tdata from bit 0 up: op[1:0], reg_address[15:0], write_data[7:0],
    // serial_in, then five ignored bits.
    input  logic [ptwcs_pkg::IN_TDATA_W-1:0]     s_tdata,

    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // m_tdata from bit 0 up: chip_select_n, serial_clock, serial_out, busy_res,
    // done_res, read_byte[7:0], read_valid, start_ignored, then one zero bit.
    output logic [ptwcs_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    ptwcs_pkg::in_item_t  s_item;
    ptwcs_pkg::in_item_t  item;
    logic                 item_valid;
    ptwcs_pkg::res_item_t res;
    ptwcs_pkg::res_item_t m_res;
    logic                 out_can_load;
    logic                 step;

    // The packed struct puts op in the lowest bits, matching the word layout.
    assign s_item = ptwcs_pkg::in_item_t'(s_tdata[ptwcs_pkg::IN_W-1:0]);

    // One tick is processed whenever a word waits in the input register and the
    // output register is empty or being drained in the same cycle.
    assign step = item_valid && out_can_load;

    ptwcs_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .step       (step),
        .item_valid (item_valid),
        .item       (item)
    );

    // The core holds the bus state: current operation, frame, bit, clock half and
    // tick counter, plus the shift word and the receive byte.
    ptwcs_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .step      (step),
        .item      (item),
        .res       (res)
    );

    ptwcs_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .res      (res),
        .can_load (out_can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (m_res)
    );

    assign m_tdata = ptwcs_pkg::OUT_TDATA_W'(m_res);

endmodule
